// ===== hdl/sgre_pkg.sv =====
// Shared constants and types for the scaled glyph row expander.
package sgre_pkg;

  localparam int GLYPH_WIDTH_DEF = 16;
  localparam int MAX_SCALE_DEF   = 4;

  localparam int ROW_WORD_W  = 32;
  localparam int ORIGIN_W    = 10;
  localparam int ROW_IDX_W   = 5;
  localparam int COORD_W     = 11;
  localparam int MASK_W      = 64;
  localparam int SCALE_W     = 3;
  localparam int SUB_W       = 2;   // enough to count the sub-rows of the largest scale
  localparam int PROD_W      = ROW_IDX_W + SCALE_W;

  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 88;
  localparam int CFG_ADDR_W  = 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_ADDR_W-1:0] REG_SCALE    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_VERTICAL = 1'b1;

  // One classified row word, ready for the span emitter.
  typedef struct packed {
    logic [MASK_W-1:0]   mask;
    logic [COORD_W-1:0]  start_coord;  // coordinate that steps with the sub-row
    logic [ORIGIN_W-1:0] fixed_coord;  // coordinate that stays put
    logic [SUB_W-1:0]    last_sub;     // number of sub-rows minus one
    logic                vertical;
  } span_job_t;

endpackage

// ===== hdl/scaled_glyph_row_expander_unit.sv =====
// Top level of the scaled glyph row expander: config registers, front end, queue, emitter.
//
// Channel   Direction  Transaction
// s_axis    in         one font row word with glyph select, origin and row index
// m_axis    out        one expanded span; tlast marks the final sub-row of a word
// cfg       in         one register write (0 scale, 1 vertical), no read-back
//
// The output emits one span per cycle while the receiver takes them; a row word gives
// scale spans (1 to 4), so it occupies the emitter until its last span is loaded. A word
// passes the front register, then the queue write, then the output register that offers it.
// The input side keeps taking words while the two-entry queue has room. Reset empties the
// pipeline and sets scale 1, horizontal text. Either side may stall freely.
module scaled_glyph_row_expander_unit
  import sgre_pkg::*;
#(
  parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF,
  parameter int MAX_SCALE   = MAX_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // row_bits[31:0], origin_col[41:32], origin_row[51:42], row_index[56:52], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // glyph_select
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // span_col[10:0], span_row[21:11], span_mask[85:22], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [SCALE_W-1:0]    cfg_wdata
);

  logic [SCALE_W-1:0] scale;
  logic               vertical;
  logic               f_valid;
  logic               f_ready;
  span_job_t          f_job;
  logic               q_valid;
  logic               q_pop;
  span_job_t          q_job;
  logic [COORD_W-1:0] span_col;
  logic [COORD_W-1:0] span_row;
  logic [MASK_W-1:0]  span_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale    <= SCALE_W'(1);
      vertical <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SCALE:    scale    <= cfg_wdata;
        REG_VERTICAL: vertical <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  sgre_front #(
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .MAX_SCALE   (MAX_SCALE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .row_bits     (s_axis_tdata[31:0]),
    .glyph_select (s_axis_tuser),
    .origin_col   (s_axis_tdata[41:32]),
    .origin_row   (s_axis_tdata[51:42]),
    .row_index    (s_axis_tdata[56:52]),
    .scale        (scale),
    .vertical     (vertical),
    .job_valid    (f_valid),
    .job_ready    (f_ready),
    .job          (f_job)
  );

  sgre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_job   (f_job),
    .head_valid (q_valid),
    .pop        (q_pop),
    .head_job   (q_job)
  );

  sgre_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_col   (span_col),
    .out_row   (span_row),
    .out_mask  (span_mask),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, span_mask, span_row, span_col};

endmodule

// ===== hdl/sgre_front.sv =====
// Front end: takes row words, expands the glyph bits and works out the span origin.
module sgre_front
  import sgre_pkg::*;
#(
  parameter int GLYPH_WIDTH = GLYPH_WIDTH_DEF,
  parameter int MAX_SCALE   = MAX_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ROW_WORD_W-1:0] row_bits,
  input  logic                  glyph_select,
  input  logic [ORIGIN_W-1:0]   origin_col,
  input  logic [ORIGIN_W-1:0]   origin_row,
  input  logic [ROW_IDX_W-1:0]  row_index,
  input  logic [SCALE_W-1:0]    scale,
  input  logic                  vertical,
  output logic                  job_valid,
  input  logic                  job_ready,
  output span_job_t             job
);

  logic [GLYPH_WIDTH-1:0] glyph_bits;
  logic [SCALE_W-1:0]     eff_scale;
  logic [PROD_W-1:0]      row_offset;
  logic [MASK_W-1:0]      mask_next;
  span_job_t              job_next;
  logic                   accept;

  // Out-of-range scale values are pinned to the nearest legal one.
  always_comb begin
    if (scale == '0) begin
      eff_scale = SCALE_W'(1);
    end else if (scale > SCALE_W'(MAX_SCALE)) begin
      eff_scale = SCALE_W'(MAX_SCALE);
    end else begin
      eff_scale = scale;
    end
  end

  always_comb begin
    for (int i = 0; i < GLYPH_WIDTH; i++) begin
      glyph_bits[i] = glyph_select ? row_bits[2*i+1] : row_bits[2*i];
    end
  end

  // Each candidate scale has its own fixed wiring; the live scale picks one.
  always_comb begin
    mask_next = '0;
    for (int k = 1; k <= MAX_SCALE; k++) begin
      if (eff_scale == SCALE_W'(k)) begin
        for (int i = 0; i < GLYPH_WIDTH; i++) begin
          for (int r = 0; r < k; r++) begin
            if (i * k + r < MASK_W) begin
              mask_next[i*k+r] = glyph_bits[i];
            end
          end
        end
      end
    end
  end

  assign row_offset = PROD_W'(row_index) * PROD_W'(eff_scale);

  always_comb begin
    job_next.mask     = mask_next;
    job_next.last_sub = SUB_W'(eff_scale - SCALE_W'(1));
    job_next.vertical = vertical;
    if (vertical) begin
      job_next.start_coord = COORD_W'(origin_col) + COORD_W'(row_offset);
      job_next.fixed_coord = origin_row;
    end else begin
      job_next.start_coord = COORD_W'(origin_row) + COORD_W'(row_offset);
      job_next.fixed_coord = origin_col;
    end
  end

  assign in_ready = !job_valid || job_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= 1'b1;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_next;
    end
  end

endmodule

// ===== hdl/sgre_queue.sv =====
// Short job queue between the front end and the span emitter.
module sgre_queue
  import sgre_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  span_job_t push_job,
  output logic      head_valid,
  input  logic      pop,
  output span_job_t head_job
);

  span_job_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_job   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("job queue holds more entries than it has");

endmodule

// ===== hdl/sgre_back.sv =====
// Span emitter: walks the sub-rows of the head job into the output register.
module sgre_back
  import sgre_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  span_job_t          job,
  output logic               job_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_col,
  output logic [COORD_W-1:0] out_row,
  output logic [MASK_W-1:0]  out_mask,
  output logic               out_last
);

  logic [SUB_W-1:0]   sub;
  logic [COORD_W-1:0] step_coord;
  logic               load;
  logic               emit;
  logic               final_sub;

  assign load       = !out_valid || out_ready;
  assign emit       = job_valid && load;
  assign final_sub  = sub == job.last_sub;
  assign job_pop    = emit && final_sub;
  assign step_coord = job.start_coord + COORD_W'(sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      sub       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        sub <= final_sub ? '0 : sub + SUB_W'(1);
      end
      if (load) begin
        out_valid <= job_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_mask <= job.mask;
      out_last <= final_sub;
      if (job.vertical) begin
        out_col <= step_coord;
        out_row <= COORD_W'(job.fixed_coord);
      end else begin
        out_col <= COORD_W'(job.fixed_coord);
        out_row <= step_coord;
      end
    end
  end

  a_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> sub <= job.last_sub)
    else $error("sub-row counter ran past the job's last sub-row");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=> (out_valid && out_mask == $past(out_mask)))
    else $error("span run broke off before its last sub-row");

  a_pop_only_on_last: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> (out_valid && out_last))
    else $error("job left the queue without its last span being loaded");

endmodule

// ===== tb/scaled_glyph_row_expander_unit_tb.sv =====
// Self-checking testbench for the scaled glyph row expander: directed and random row words.
`timescale 1ns / 1ps

module scaled_glyph_row_expander_unit_tb;
  import sgre_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 47;

  typedef struct {
    logic [ROW_WORD_W-1:0] row_bits;
    logic                  glyph_select;
    logic [ORIGIN_W-1:0]   origin_col;
    logic [ORIGIN_W-1:0]   origin_row;
    logic [ROW_IDX_W-1:0]  row_index;
  } glyph_row_t;

  typedef struct {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [MASK_W-1:0]  mask;
    logic               last;
  } span_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [SCALE_W-1:0]    cfg_wdata = '0;

  glyph_row_t  pending_rows[$];
  span_t       expected_spans[$];
  glyph_row_t  offered_row;
  logic [SCALE_W-1:0] scale_shadow = 3'd1;
  logic        vertical_shadow = 1'b0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fault_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_req_cnt = 0;
  int unsigned hold_ack_cnt = 0;
  int unsigned hold_left = 0;

  scaled_glyph_row_expander_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int unsigned used_scale(input logic [SCALE_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MAX_SCALE_DEF) return MAX_SCALE_DEF;
    return int'(raw);
  endfunction

  function automatic logic [MASK_W-1:0] expand_glyph_row(input logic [ROW_WORD_W-1:0] word,
                                                         input logic sel,
                                                         input int unsigned s);
    logic [MASK_W-1:0] mask;
    int unsigned pos;
    mask = '0;
    pos = 0;
    for (int i = 0; i < GLYPH_WIDTH_DEF; i++) begin
      for (int k = 0; k < s; k++) begin
        if (word[sel + 2 * i] && pos < MASK_W) mask[pos] = 1'b1;
        pos++;
      end
    end
    return mask;
  endfunction

  // Queues the spans that one accepted row word should produce, using the live settings.
  task automatic predict_spans(input glyph_row_t g);
    int unsigned s;
    logic [MASK_W-1:0] mask;
    logic [COORD_W-1:0] step_base;
    span_t sp;
    s = used_scale(scale_shadow);
    mask = expand_glyph_row(g.row_bits, g.glyph_select, s);
    step_base = COORD_W'(int'(g.row_index) * s);
    for (int l = 0; l < s; l++) begin
      if (vertical_shadow) begin
        sp.col = COORD_W'(g.origin_col + step_base + l);
        sp.row = COORD_W'(g.origin_row);
      end else begin
        sp.col = COORD_W'(g.origin_col);
        sp.row = COORD_W'(g.origin_row + step_base + l);
      end
      sp.mask = mask;
      sp.last = (l + 1 == s);
      expected_spans.push_back(sp);
    end
  endtask

  task automatic report_fault(input string what);
    if (fault_cnt < 10) $display("%t: %s", $realtime, what);
    fault_cnt++;
  endtask

  // Driver: offers the next pending row word, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_spans(offered_row);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_rows.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered_row = pending_rows.pop_front();
          s_axis_tdata <= {7'd0, offered_row.row_index, offered_row.origin_row,
                           offered_row.origin_col, offered_row.row_bits};
          s_axis_tuser <= offered_row.glyph_select;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the receiver, started on request from the stimulus.
  always @(posedge clk) begin
    if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each span transaction against the oldest expectation.
  always @(posedge clk) begin
    span_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_spans.size() == 0) begin
          report_fault($sformatf("unexpected span col=%0d row=%0d mask=%h last=%b",
                                 m_axis_tdata[10:0], m_axis_tdata[21:11],
                                 m_axis_tdata[85:22], m_axis_tlast));
        end else begin
          want = expected_spans.pop_front();
          if (m_axis_tdata[10:0] !== want.col || m_axis_tdata[21:11] !== want.row ||
              m_axis_tdata[85:22] !== want.mask || m_axis_tlast !== want.last)
            report_fault($sformatf(
              {"span mismatch: expected col=%0d row=%0d mask=%h last=%b, ",
               "got col=%0d row=%0d mask=%h last=%b"},
              want.col, want.row, want.mask, want.last, m_axis_tdata[10:0],
              m_axis_tdata[21:11], m_axis_tdata[85:22], m_axis_tlast));
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("scaled_glyph_row_expander_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [SCALE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    if (idx == REG_SCALE) scale_shadow = val;
    else vertical_shadow = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // The upper data bits of a vertical write are noise that the block must drop.
  task automatic set_layout(input logic [SCALE_W-1:0] scale_val, input logic vert);
    write_reg(REG_SCALE, scale_val);
    write_reg(REG_VERTICAL, {2'($urandom_range(3)), vert});
  endtask

  task automatic wait_idle();
    while (pending_rows.size() != 0 || s_axis_tvalid || expected_spans.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_row(input logic [ROW_WORD_W-1:0] bits, input logic sel,
                          input logic [ORIGIN_W-1:0] ocol, input logic [ORIGIN_W-1:0] orow,
                          input logic [ROW_IDX_W-1:0] ridx);
    glyph_row_t g;
    g.row_bits = bits;
    g.glyph_select = sel;
    g.origin_col = ocol;
    g.origin_row = orow;
    g.row_index = ridx;
    pending_rows.push_back(g);
  endtask

  function automatic logic [ORIGIN_W-1:0] pick_origin();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return ORIGIN_W'($urandom_range(1023));
    endcase
  endfunction

  task automatic push_random_row();
    logic [ROW_WORD_W-1:0] bits;
    case ($urandom_range(9))
      0: bits = '0;
      1: bits = '1;
      default: bits = $urandom;
    endcase
    push_row(bits, 1'($urandom_range(1)), pick_origin(), pick_origin(),
             ROW_IDX_W'($urandom_range(31)));
  endtask

  task automatic set_idling(input int mode);
    sender_idle_pct = (mode == 1) ? 73 : (mode == 3) ? 7 : 0;
    recv_stall_pct  = (mode == 2) ? 73 : (mode == 3) ? 7 : 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings, then at the extremes and out-of-range scales.
    push_row('0, 1'b0, '0, '0, '0);
    push_row('1, 1'b1, '1, '1, 5'd31);
    push_row(32'hAAAA_AAAA, 1'b0, 10'd100, 10'd200, 5'd3);
    push_row(32'hAAAA_AAAA, 1'b1, 10'd5, 10'd6, 5'd7);
    wait_idle();
    set_layout(3'd0, 1'b1);
    push_row(32'h5555_5555, 1'b0, '1, '1, 5'd31);
    push_row(32'h5555_5555, 1'b1, '0, '0, '0);
    push_row(32'h8000_0001, 1'b1, 10'd512, 10'd511, 5'd16);
    wait_idle();
    set_layout(3'd4, 1'b0);
    push_row('1, 1'b0, '1, '1, 5'd31);
    push_row(32'h8000_0001, 1'b0, '0, '0, '0);
    push_row(32'hC000_0003, 1'b1, 10'd1, 10'd2, 5'd1);
    push_row(32'h1234_5678, 1'b1, 10'd700, 10'd300, 5'd31);
    wait_idle();
    set_layout(3'd7, 1'b1);
    push_row('1, 1'b1, '1, '1, 5'd31);
    push_row(32'hF0F0_F0F0, 1'b0, '0, '1, 5'd8);
    push_row(32'h0F0F_0F0F, 1'b1, '1, '0, 5'd20);
    push_row('0, 1'b1, 10'd9, 10'd9, 5'd2);
    wait_idle();
    set_layout(3'd2, 1'b0);
    push_row(32'hDEAD_BEEF, 1'b0, '1, '1, 5'd31);
    push_row(32'h0000_FFFF, 1'b1, '0, '0, 5'd1);
    push_row(32'hFFFF_0000, 1'b0, 10'd33, 10'd44, 5'd30);
    wait_idle();
    set_layout(3'd3, 1'b1);
    push_row(32'hCAFE_F00D, 1'b1, '1, '1, 5'd31);
    push_row(32'h0000_0001, 1'b0, '0, '0, '0);
    push_row(32'h8000_0000, 1'b1, 10'd2, 10'd3, 5'd4);
    wait_idle();

    // Random phases, each under its own settings and idling pattern.
    for (int p = 0; p < 8; p++) begin
      set_layout(SCALE_W'($urandom_range(7)), 1'($urandom_range(1)));
      set_idling(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) push_random_row();
      wait_idle();
    end

    // The receiver holds off while the sender keeps offering, so the block backs up.
    set_layout(3'd4, 1'($urandom_range(1)));
    set_idling(0);
    for (int n = 0; n < 40; n++) push_random_row();
    hold_req_cnt = hold_req_cnt + 1;
    wait_idle();
    repeat (20) @(posedge clk);

    if (expected_spans.size() != 0)
      report_fault($sformatf("%0d expected spans never arrived", expected_spans.size()));
    if (fault_cnt == 0) begin
      $display("scaled_glyph_row_expander_unit_tb: done, clean");
    end else begin
      $display("scaled_glyph_row_expander_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sgre_pkg.sv
hdl/sgre_front.sv
hdl/sgre_queue.sv
hdl/sgre_back.sv
hdl/scaled_glyph_row_expander_unit.sv
tb/scaled_glyph_row_expander_unit_tb.sv
